[design/mrir_pkg.sv]
// ============================================================================
// mrir_pkg
// Shared types, constants and the CRC-16 step for the Modbus read input
// register responder.
// ============================================================================
`default_nettype none

package mrir_pkg;

    localparam int TABLE_DEPTH_DEF = 256;
    localparam int MAX_COUNT_DEF   = 29;

    localparam logic [7:0]  FUNC_READ_INPUT = 8'd4;
    localparam int          HEADER_LEN      = 6;
    localparam logic [7:0]  LAST_HDR_POS    = 8'd6;   // frame of 8+ bytes ends at pos 7+
    localparam logic [7:0]  POS_MAX         = 8'd255;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;

    localparam logic OP_FRAME_BYTE = 1'b0;
    localparam logic OP_REG_WRITE  = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [7:0]  reg_index;
        logic [15:0] reg_value;
    } req_item_t;

    typedef struct packed {
        logic [7:0] resp_byte;
        logic       resp_last;
    } resp_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_ADDR,
        S_FUNC,
        S_BCNT,
        S_RDHI,
        S_RDLO,
        S_RDWAIT,
        S_CRCLO,
        S_CRCHI
    } state_t;

    typedef enum logic [2:0] {
        SEL_ADDR,
        SEL_FUNC,
        SEL_BCNT,
        SEL_RHI,
        SEL_RLO,
        SEL_CRCLO,
        SEL_CRCHI
    } emit_sel_t;

    // controller -> datapath
    typedef struct packed {
        logic      clr_step;   // write zero at clear address, advance
        logic      accept;     // request taken this cycle
        logic      resp_init;  // restart tx CRC and register counter
        logic      emit;       // load output register
        emit_sel_t sel;        // source of emitted byte
        logic      cnt_inc;    // next register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_done;
        logic frame_end;   // pending request is the last frame byte
        logic resp_ok;     // stored frame asks for a valid response
        logic count_zero;
        logic cnt_last;
        logic out_free;
    } ctrl_stat_t;

    // one byte through the reflected Modbus CRC-16
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[design/modbus_read_input_responder.sv]
// After the last request byte the sequencer passes S_CHECK, then S_ADDR loads the
// first response byte into the output register once it is free. Throughput: one
// request per cycle while idle; intake stays closed for the whole response, and each
// register walks S_RDHI, S_RDLO and S_RDWAIT (none after the last) for the table read.
// Reset: a clearing pass writes zero to every table entry with req_ready low;
// CRCs restart at 0xFFFF and the frame position at zero.
// ============================================================================
// modbus_read_input_responder
// Modbus RTU slave for function 4 (read input registers) over a byte stream.
// ============================================================================
`default_nettype none

module modbus_read_input_responder #(
    parameter int TABLE_DEPTH = mrir_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_COUNT   = mrir_pkg::MAX_COUNT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire mrir_pkg::req_item_t   req,
    output logic                       resp_valid,
    input  wire logic                  resp_ready,
    output mrir_pkg::resp_item_t       resp
);
    import mrir_pkg::*;

    ctrl_cmd_t  cmd;
    ctrl_stat_t stat;

    // sequencer
    mrir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // table, CRCs and output register
    mrir_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_COUNT   (MAX_COUNT)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .cmd        (cmd),
        .stat       (stat),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

`ifndef ASSERT_OFF
    // frame end always goes through the check cycle with intake closed
    a_check_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (req.opcode == OP_FRAME_BYTE) && req.last_byte)
        |=> !req_ready)
        else $error("request taken in the frame check cycle");

    // a waiting response byte holds until taken
    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (resp_valid && !resp_ready) |=> (resp_valid && $stable(resp)))
        else $error("response byte changed while waiting");
`endif

endmodule

`default_nettype wire

[design/mrir_ctrl.sv]
// ============================================================================
// mrir_ctrl
// Sequencer: table clear after reset, request intake, frame check and the
// response byte walk.
// ============================================================================
`default_nettype none

module mrir_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  req_valid,
    output logic                       req_ready,
    input  wire mrir_pkg::ctrl_stat_t  stat,
    output mrir_pkg::ctrl_cmd_t        cmd
);
    import mrir_pkg::*;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        req_ready     = 1'b0;
        cmd.clr_step  = 1'b0;
        cmd.accept    = 1'b0;
        cmd.resp_init = 1'b0;
        cmd.emit      = 1'b0;
        cmd.sel       = SEL_ADDR;
        cmd.cnt_inc   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_done)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
                if (req_valid && stat.frame_end)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.resp_init = 1'b1;
                state_next    = stat.resp_ok ? S_ADDR : S_IDLE;
            end
            S_ADDR:
            begin
                cmd.sel = SEL_ADDR;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_FUNC;
                end
            end
            S_FUNC:
            begin
                cmd.sel = SEL_FUNC;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_BCNT;
                end
            end
            S_BCNT:
            begin
                cmd.sel = SEL_BCNT;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = stat.count_zero ? S_CRCLO : S_RDHI;
                end
            end
            S_RDHI:
            begin
                cmd.sel = SEL_RHI;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_RDLO;
                end
            end
            S_RDLO:
            begin
                cmd.sel = SEL_RLO;
                if (stat.out_free)
                begin
                    cmd.emit    = 1'b1;
                    cmd.cnt_inc = 1'b1;
                    state_next  = stat.cnt_last ? S_CRCLO : S_RDWAIT;
                end
            end
            S_RDWAIT:
            begin
                // table read of the next register lands here
                state_next = S_RDHI;
            end
            S_CRCLO:
            begin
                cmd.sel = SEL_CRCLO;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_CRCHI;
                end
            end
            S_CRCHI:
            begin
                cmd.sel = SEL_CRCHI;
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[design/mrir_datapath.sv]
// ============================================================================
// mrir_datapath
// Input register table, frame header capture, receive and transmit CRCs,
// response byte selection and the output register.
// ============================================================================
`default_nettype none

module mrir_datapath #(
    parameter int TABLE_DEPTH = mrir_pkg::TABLE_DEPTH_DEF,
    parameter int MAX_COUNT   = mrir_pkg::MAX_COUNT_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mrir_pkg::req_item_t   req,
    input  wire mrir_pkg::ctrl_cmd_t   cmd,
    output mrir_pkg::ctrl_stat_t       stat,
    output logic                       resp_valid,
    input  wire logic                  resp_ready,
    output mrir_pkg::resp_item_t       resp
);
    import mrir_pkg::*;

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_COUNT + 1);

    // table memory
    logic [15:0]       mem [TABLE_DEPTH];
    logic [15:0]       rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic              wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [16:0]       rd_sum;

    // frame state
    logic [7:0]        hdr_reg [HEADER_LEN];
    logic [7:0]        pos_reg;
    logic [15:0]       rx_crc_reg;
    logic [15:0]       rx_crc_new;
    logic              good_reg;
    logic [15:0]       tx_crc_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W:0]    cnt_plus;

    logic [15:0]       start_w;
    logic [15:0]       count_w;
    logic [16:0]       range_end;
    logic              byte_acc;
    logic              write_acc;
    logic              idx_ok;

    logic [7:0]        emit_byte;
    logic              out_valid_reg;
    resp_item_t        out_reg;

    assign byte_acc  = cmd.accept && (req.opcode == OP_FRAME_BYTE);
    assign write_acc = cmd.accept && (req.opcode == OP_REG_WRITE);
    assign idx_ok    = {9'd0, req.reg_index} < 17'(TABLE_DEPTH);

    assign start_w   = {hdr_reg[2], hdr_reg[3]};
    assign count_w   = {hdr_reg[4], hdr_reg[5]};
    assign range_end = {1'b0, start_w} + {1'b0, count_w};
    assign rd_sum    = {1'b0, start_w} + {{(17 - CNT_W){1'b0}}, cnt_reg};
    assign rd_addr   = rd_sum[ADDR_W-1:0];
    assign cnt_plus  = {1'b0, cnt_reg} + {{CNT_W{1'b0}}, 1'b1};

    assign rx_crc_new = crc_update(rx_crc_reg, req.data_byte);

    // write port: clearing pass or register write
    always_comb
    begin
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_reg;
            wr_data = 16'h0000;
        end
        else
        begin
            wr_en   = write_acc && idx_ok;
            wr_addr = ADDR_W'(req.reg_index);
            wr_data = req.reg_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    // clear address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clr_step)
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
    end

    // request frame intake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= 8'd0;
            rx_crc_reg <= CRC_INIT;
            good_reg   <= 1'b0;
            for (int i = 0; i < HEADER_LEN; i++)
                hdr_reg[i] <= 8'd0;
        end
        else if (byte_acc)
        begin
            if (pos_reg < 8'(HEADER_LEN))
                hdr_reg[pos_reg[2:0]] <= req.data_byte;
            if (req.last_byte)
            begin
                pos_reg    <= 8'd0;
                rx_crc_reg <= CRC_INIT;
                good_reg   <= (pos_reg > LAST_HDR_POS) && (rx_crc_new == 16'h0000);
            end
            else
            begin
                rx_crc_reg <= rx_crc_new;
                if (pos_reg != POS_MAX)
                    pos_reg <= pos_reg + 8'd1;
            end
        end
    end

    // response byte source
    always_comb
    begin
        case (cmd.sel)
            SEL_ADDR:  emit_byte = hdr_reg[0];
            SEL_FUNC:  emit_byte = hdr_reg[1];
            SEL_BCNT:  emit_byte = {count_w[6:0], 1'b0};
            SEL_RHI:   emit_byte = rd_data_reg[15:8];
            SEL_RLO:   emit_byte = rd_data_reg[7:0];
            SEL_CRCLO: emit_byte = tx_crc_reg[7:0];
            SEL_CRCHI: emit_byte = tx_crc_reg[15:8];
            default:   emit_byte = 8'h00;
        endcase
    end

    // transmit CRC and register counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_crc_reg <= CRC_INIT;
            cnt_reg    <= '0;
        end
        else if (cmd.resp_init)
        begin
            tx_crc_reg <= CRC_INIT;
            cnt_reg    <= '0;
        end
        else
        begin
            if (cmd.emit && (cmd.sel != SEL_CRCLO) && (cmd.sel != SEL_CRCHI))
                tx_crc_reg <= crc_update(tx_crc_reg, emit_byte);
            if (cmd.cnt_inc)
                cnt_reg <= cnt_plus[CNT_W-1:0];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (resp_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg.resp_byte <= emit_byte;
            out_reg.resp_last <= (cmd.sel == SEL_CRCHI);
        end
    end

    assign resp_valid = out_valid_reg;
    assign resp       = out_reg;

    // status
    assign stat.clr_done   = (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign stat.frame_end  = (req.opcode == OP_FRAME_BYTE) && req.last_byte;
    assign stat.resp_ok    = good_reg && (hdr_reg[1] == FUNC_READ_INPUT)
                             && (count_w <= 16'(MAX_COUNT))
                             && (range_end <= 17'(TABLE_DEPTH));
    assign stat.count_zero = (count_w == 16'd0);
    assign stat.cnt_last   = (cnt_plus == count_w[CNT_W:0]);
    assign stat.out_free   = !out_valid_reg || resp_ready;

endmodule

`default_nettype wire

[tb/tb_modbus_read_input_responder.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_modbus_read_input_responder
// Self-checking bench for the function 4 read input register responder.
// Frames are built with their own CRC and fed byte by byte, mixed with table
// writes. A scoreboard keeps a copy of the register table and frame state,
// works out every response byte, and checks each one on the response channel.
// Both sides idle and stall at random over several phases.
// ============================================================================

import mrir_pkg::*;

// Scoreboard: shadow register table, frame tracking and response checking
class modbus_resp_scoreboard;
    logic [15:0] input_regs [TABLE_DEPTH_DEF];
    logic [7:0]  header [HEADER_LEN];
    logic [7:0]  rx_pos;
    logic [15:0] rx_crc;
    logic [15:0] tx_crc;
    resp_item_t  expected_bytes [$];
    int          requests_seen;
    int          writes_seen;
    int          frames_answered;
    int          frames_dropped;
    int          bytes_checked;
    int          mismatches;

    function new();
        foreach (input_regs[i]) input_regs[i] = 16'h0000;
        foreach (header[i]) header[i] = 8'h00;
        rx_pos          = 8'd0;
        rx_crc          = CRC_INIT;
        tx_crc          = CRC_INIT;
        requests_seen   = 0;
        writes_seen     = 0;
        frames_answered = 0;
        frames_dropped  = 0;
        bytes_checked   = 0;
        mismatches      = 0;
    endfunction

    // Modbus CRC-16, reflected, one byte
    static function logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
        return c;
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction

    // queue one response byte ahead of the CRC and fold it into the tx CRC
    function void queue_body_byte(input logic [7:0] b);
        resp_item_t e;
        e.resp_byte = b;
        e.resp_last = 1'b0;
        expected_bytes.push_back(e);
        tx_crc = crc_step(tx_crc, b);
    endfunction

    // accepted request: update state, queue the response it causes
    function void note_request(input req_item_t it);
        int unsigned frame_len;
        int unsigned reg_start;
        int unsigned reg_count;
        logic [15:0] residue;
        logic [15:0] r;
        resp_item_t  e;
        requests_seen++;
        if (it.opcode == OP_REG_WRITE) begin
            writes_seen++;
            if (int'(it.reg_index) < TABLE_DEPTH_DEF)
                input_regs[it.reg_index] = it.reg_value;
            return;
        end

        // frame byte: keep header, run CRC, saturate position
        if (rx_pos < HEADER_LEN)
            header[rx_pos] = it.data_byte;
        rx_crc = crc_step(rx_crc, it.data_byte);
        frame_len = int'(rx_pos) + 1;
        if (rx_pos != 8'hFF)
            rx_pos++;
        if (!it.last_byte)
            return;

        // end of frame: always restart
        residue = rx_crc;
        rx_pos  = 8'd0;
        rx_crc  = CRC_INIT;
        if (frame_len < 8 || residue != 16'h0000 || header[1] != FUNC_READ_INPUT) begin
            frames_dropped++;
            return;
        end
        reg_start = 32'({header[2], header[3]});
        reg_count = 32'({header[4], header[5]});
        if (reg_count > MAX_COUNT_DEF || reg_start + reg_count > TABLE_DEPTH_DEF) begin
            frames_dropped++;
            return;
        end

        // response: address, function, byte count, registers, CRC low/high
        frames_answered++;
        tx_crc = CRC_INIT;
        queue_body_byte(header[0]);
        queue_body_byte(header[1]);
        queue_body_byte(8'(reg_count * 2));
        for (int unsigned i = 0; i < reg_count; i++) begin
            r = input_regs[reg_start + i];
            queue_body_byte(r[15:8]);
            queue_body_byte(r[7:0]);
        end
        e.resp_byte = tx_crc[7:0];
        e.resp_last = 1'b0;
        expected_bytes.push_back(e);
        e.resp_byte = tx_crc[15:8];
        e.resp_last = 1'b1;
        expected_bytes.push_back(e);
        tx_crc = CRC_INIT;
    endfunction

    // accepted response byte against the oldest expectation
    function void check_response(input resp_item_t got);
        resp_item_t e;
        if (expected_bytes.size() == 0) begin
            $error("response byte %02h (last %0b) with nothing expected",
                   got.resp_byte, got.resp_last);
            mismatches++;
            return;
        end
        e = expected_bytes.pop_front();
        bytes_checked++;
        if (got.resp_byte !== e.resp_byte) begin
            $error("resp_byte: expected %02h, got %02h", e.resp_byte, got.resp_byte);
            mismatches++;
        end
        if (got.resp_last !== e.resp_last) begin
            $error("resp_last: expected %0b, got %0b", e.resp_last, got.resp_last);
            mismatches++;
        end
    endfunction
endclass

module tb_modbus_read_input_responder;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 12;
    localparam int PHASE_ITEMS  = 20;

    logic       clk        = 1'b0;
    logic       rst_n      = 1'b0;
    logic       req_valid  = 1'b0;
    logic       req_ready;
    req_item_t  req        = '0;
    logic       resp_valid;
    logic       resp_ready = 1'b0;
    resp_item_t resp;

    modbus_resp_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int items_sent     = 0;
    int hold_asks      = 0;
    int hold_seen      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;

    int send_idle_tbl [4] = '{0, 78, 0, 12};
    int recv_stall_tbl [4] = '{0, 0, 78, 12};

    modbus_read_input_responder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d response bytes outstanding",
                   cycle_count, sb.pending());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // response side: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_seen != hold_asks) begin
            hold_seen = hold_asks;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            resp_ready <= 1'b0;
        else if (hold_left > 0) begin
            hold_left--;
            resp_ready <= 1'b0;
        end
        else
            resp_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // response check at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && resp_valid && resp_ready)
            sb.check_response(resp);
    end

    function automatic req_item_t frame_byte_item(input logic [7:0] b, input logic last);
        req_item_t it;
        it.opcode    = OP_FRAME_BYTE;
        it.data_byte = b;
        it.last_byte = last;
        it.reg_index = 8'($urandom_range(255));
        it.reg_value = 16'($urandom_range(65535));
        return it;
    endfunction

    function automatic req_item_t reg_write_item(input logic [7:0] idx, input logic [15:0] val);
        req_item_t it;
        it.opcode    = OP_REG_WRITE;
        it.data_byte = 8'($urandom_range(255));
        it.last_byte = 1'($urandom_range(1));
        it.reg_index = idx;
        it.reg_value = val;
        return it;
    endfunction

    // random write, mostly into the low window that reads tend to cover
    function automatic req_item_t random_write_item();
        logic [7:0] idx;
        idx = ($urandom_range(99) < 80) ? 8'($urandom_range(63)) : 8'($urandom_range(255));
        return reg_write_item(idx, 16'($urandom_range(65535)));
    endfunction

    // entered and left at a falling edge; valid stays up between requests
    task automatic send_request(input req_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (!req_ready);
        sb.note_request(it);
        items_sent++;
        @(negedge clk);
    endtask

    // build a frame with a valid CRC, optionally damaged, and send it
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] func,
                              input logic [15:0] reg_start, input logic [15:0] reg_count,
                              input int body_len, input int extra_len,
                              input bit corrupt, input int write_pct);
        logic [7:0]  hdr [6];
        logic [7:0]  frame_bytes [$];
        logic [15:0] crc;
        int          k;
        hdr = '{addr, func, reg_start[15:8], reg_start[7:0], reg_count[15:8], reg_count[7:0]};
        crc = CRC_INIT;
        for (k = 0; k < body_len; k++)
            frame_bytes.push_back(hdr[k]);
        for (k = 0; k < extra_len; k++)
            frame_bytes.push_back(8'($urandom_range(255)));
        for (k = 0; k < frame_bytes.size(); k++)
            crc = sb.crc_step(crc, frame_bytes[k]);
        frame_bytes.push_back(crc[7:0]);
        frame_bytes.push_back(crc[15:8]);
        // single bit flip always breaks the CRC
        if (corrupt) begin
            k = $urandom_range(frame_bytes.size() - 1);
            frame_bytes[k] = frame_bytes[k] ^ (8'h01 << $urandom_range(7));
        end
        for (k = 0; k < frame_bytes.size(); k++) begin
            if ($urandom_range(99) < write_pct)
                send_request(random_write_item());
            send_request(frame_byte_item(frame_bytes[k], k == frame_bytes.size() - 1));
        end
    endtask

    // mostly good read requests, the rest malformed or noise
    task automatic send_random_frame();
        int          kind;
        int          n;
        logic [15:0] cnt;
        logic [15:0] first;
        logic [7:0]  func;
        kind = $urandom_range(99);
        cnt  = ($urandom_range(9) == 0) ? 16'(MAX_COUNT_DEF) : 16'($urandom_range(12));
        first = ($urandom_range(99) < 75) ? 16'($urandom_range(40))
                                          : 16'($urandom_range(TABLE_DEPTH_DEF - cnt));
        n = $urandom_range(3);
        repeat (n) send_request(random_write_item());
        if (kind < 68)
            send_frame(8'($urandom_range(255)), FUNC_READ_INPUT, first, cnt, 6,
                       ($urandom_range(9) == 0) ? $urandom_range(1, 3) : 0, 0, 12);
        else if (kind < 76)
            send_frame(8'($urandom_range(255)), FUNC_READ_INPUT, first, cnt, 6, 0, 1, 12);
        else if (kind < 82) begin
            func = 8'($urandom_range(255));
            if (func == FUNC_READ_INPUT)
                func = 8'h03;
            send_frame(8'($urandom_range(255)), func, first, cnt, 6, 0, 0, 12);
        end
        else if (kind < 87)
            send_frame(8'($urandom_range(255)), FUNC_READ_INPUT, first,
                       16'($urandom_range(65535, MAX_COUNT_DEF + 1)), 6, 0, 0, 12);
        else if (kind < 92)
            send_frame(8'($urandom_range(255)), FUNC_READ_INPUT,
                       16'($urandom_range(65535, TABLE_DEPTH_DEF - cnt + 1)), cnt, 6, 0, 0, 12);
        else if (kind < 96)
            send_frame(8'($urandom_range(255)), FUNC_READ_INPUT, first, cnt,
                       $urandom_range(5), 0, 0, 12);
        else
            send_frame(8'($urandom_range(255)), 8'($urandom_range(255)), 16'($urandom),
                       16'($urandom), 0, $urandom_range(1, 12), $urandom_range(1), 12);
    endtask

    // sender pauses until every expected response byte has been taken
    task automatic wait_drain();
        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.pending() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    // main sequence
    initial
    begin
        int phase;
        int phase_start;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: table extremes, then each frame case
        send_request(reg_write_item(8'd0,   16'hFFFF));
        send_request(reg_write_item(8'd1,   16'h0000));
        send_request(reg_write_item(8'd2,   16'hA55A));
        send_request(reg_write_item(8'd227, 16'h1234));
        send_request(reg_write_item(8'd255, 16'h8001));
        send_frame(8'h01, FUNC_READ_INPUT, 16'd0,   16'd3,  6, 0, 0, 0);
        send_frame(8'hFF, FUNC_READ_INPUT, 16'd5,   16'd0,  6, 0, 0, 0);
        send_frame(8'h00, FUNC_READ_INPUT, 16'd227, 16'(MAX_COUNT_DEF), 6, 0, 0, 0);
        send_frame(8'h02, FUNC_READ_INPUT, 16'd0,   16'(MAX_COUNT_DEF + 1), 6, 0, 0, 0);
        send_frame(8'h03, FUNC_READ_INPUT, 16'd0,   16'h0100, 6, 0, 0, 0);
        send_frame(8'h04, FUNC_READ_INPUT, 16'd250, 16'd7,  6, 0, 0, 0);
        send_frame(8'h05, FUNC_READ_INPUT, 16'hFFFF, 16'd1, 6, 0, 0, 0);
        send_frame(8'h06, FUNC_READ_INPUT, 16'd0,   16'd2,  5, 0, 0, 0);
        send_frame(8'h07, FUNC_READ_INPUT, 16'd0,   16'd2,  6, 0, 1, 0);
        send_frame(8'h08, 8'h03,           16'd0,   16'd2,  6, 0, 0, 0);
        send_frame(8'h09, FUNC_READ_INPUT, 16'd0,   16'd2,  6, 4, 0, 0);
        send_frame(8'h0A, FUNC_READ_INPUT, 16'd0,   16'd4,  6, 0, 0, 60);
        wait_drain();

        // random phases with different idle and stall mixes
        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_idle_tbl[phase];
            recv_stall_pct = recv_stall_tbl[phase];
            phase_start    = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_frame();
            wait_drain();
        end

        // back-pressure: receiver holds off while full-size reads keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asks++;
        repeat (4)
            send_frame(8'($urandom_range(255)), FUNC_READ_INPUT,
                       16'($urandom_range(TABLE_DEPTH_DEF - MAX_COUNT_DEF)),
                       16'(MAX_COUNT_DEF), 6, 0, 0, 20);
        wait_drain();
        repeat (SETTLE) @(negedge clk);

        $display("Covered %0d requests (%0d table writes): %0d frames answered, %0d dropped,",
                 sb.requests_seen, sb.writes_seen, sb.frames_answered, sb.frames_dropped);
        $display("%0d response bytes checked over idle, stall and hold-off phases",
                 sb.bytes_checked);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[filelist.f]
design/mrir_pkg.sv
design/mrir_ctrl.sv
design/mrir_datapath.sv
design/modbus_read_input_responder.sv
tb/tb_modbus_read_input_responder.sv
